>>> src/mrw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrw_pkg
// Shared widths and verdict codes for the Miller-Rabin witness round.
// ----------------------------------------------------------------------------
package mrw_pkg;

	localparam int WIDTH = 32;
	localparam int CNT_W = $clog2(WIDTH);

	localparam logic [1:0] V_REJECT    = 2'd0;
	localparam logic [1:0] V_COMPOSITE = 2'd1;
	localparam logic [1:0] V_PASS      = 2'd2;

endpackage

>>> src/miller_rabin_witness_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miller_rabin_witness_round
// One Miller-Rabin round: candidate n, witness a, one verdict.
//
// Usage:
//   Command channel: a transfer happens at a rising edge with start high and
//   busy low; candidate and witness are sampled there. busy stays high until
//   the verdict is out.
//   Result channel: verdict is valid for exactly one cycle with done high;
//   the receiver cannot stall it. 0 = rejected (even or at most 2),
//   1 = composite by this witness, 2 = round passed.
//   A rejected candidate goes straight to the finishing state. Otherwise
//   every modular product runs on one shared add/compare/subtract unit,
//   one multiplier bit at a time in a double phase and an add phase. The
//   witness reduction is one product, the exponentiation at most 61, the
//   final squarings the rest, at most 62 in all; the worst case is set by
//   that unit.
//   One item at a time: a new transfer is taken in the cycle done is high.
//   Reset: asynchronous, active low; returns to idle, no result pending.
// ----------------------------------------------------------------------------
module miller_rabin_witness_round (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [mrw_pkg::WIDTH-1:0] candidate,
	input  logic [mrw_pkg::WIDTH-1:0] witness,
	output logic                     done,
	output logic [1:0]               verdict
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SPLIT = 3'd1;
	localparam logic [2:0] S_EXP   = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_CHK   = 3'd4;
	localparam logic [2:0] S_SQL   = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	localparam logic [1:0] OP_RED = 2'd0;
	localparam logic [1:0] OP_ACC = 2'd1;
	localparam logic [1:0] OP_SQB = 2'd2;
	localparam logic [1:0] OP_SQX = 2'd3;

	localparam int W  = mrw_pkg::WIDTH;
	localparam int CW = mrw_pkg::CNT_W;

	logic [2:0]    state_q;
	logic          done_q;
	logic [1:0]    verdict_q;
	logic [1:0]    op_q;
	logic          ph_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] rem_q;
	logic [W-1:0]  n_q;
	logic [W-1:0]  a_q;
	logic [W-1:0]  d_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  mx_q;
	logic [W-1:0]  my_q;
	logic [W-1:0]  r_q;

	logic [W:0]    tmp;
	logic [W:0]    diff;
	logic [W-1:0]  red;
	logic [W-1:0]  n_m1;
	logic          reject;

	// shared unit: double or add, then one conditional subtract of n
	always_comb begin
		if (ph_q) begin
			tmp = {1'b0, r_q} + (mx_q[W-1] ? {1'b0, my_q} : {(W+1){1'b0}});
		end else begin
			tmp = {r_q, 1'b0};
		end
		diff = tmp - {1'b0, n_q};
		red  = (tmp >= {1'b0, n_q}) ? diff[W-1:0] : tmp[W-1:0];
	end

	assign n_m1   = n_q - {{(W-1){1'b0}}, 1'b1};
	assign reject = ~candidate[0] || (candidate <= W'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			ph_q    <= 1'b0;
			cnt_q   <= '0;
			op_q    <= OP_RED;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						n_q <= candidate;
						a_q <= witness;
						if (reject) begin
							verdict_q <= mrw_pkg::V_REJECT;
							state_q   <= S_FIN;
						end else begin
							d_q     <= (candidate - {{(W-1){1'b0}}, 1'b1}) >> 1;
							rem_q   <= '0;
							state_q <= S_SPLIT;
						end
					end
				end
				S_SPLIT: begin
					if (d_q[0]) begin
						mx_q    <= a_q;
						my_q    <= {{(W-1){1'b0}}, 1'b1};
						r_q     <= '0;
						cnt_q   <= CW'(W - 1);
						ph_q    <= 1'b0;
						op_q    <= OP_RED;
						state_q <= S_MUL;
					end else begin
						d_q   <= d_q >> 1;
						rem_q <= rem_q + CW'(1);
					end
				end
				S_EXP: begin
					if (d_q[0]) begin
						mx_q    <= acc_q;
						my_q    <= b_q;
						r_q     <= '0;
						cnt_q   <= CW'(W - 1);
						ph_q    <= 1'b0;
						op_q    <= OP_ACC;
						state_q <= S_MUL;
					end else if (d_q == '0) begin
						state_q <= S_CHK;
					end else begin
						d_q     <= d_q >> 1;
						mx_q    <= b_q;
						my_q    <= b_q;
						r_q     <= '0;
						cnt_q   <= CW'(W - 1);
						ph_q    <= 1'b0;
						op_q    <= OP_SQB;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					r_q <= red;
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q  <= 1'b0;
						mx_q  <= mx_q << 1;
						cnt_q <= cnt_q - CW'(1);
						if (cnt_q == '0) begin
							unique case (op_q)
								OP_RED: begin
									b_q     <= red;
									acc_q   <= {{(W-1){1'b0}}, 1'b1};
									state_q <= S_EXP;
								end
								OP_ACC: begin
									acc_q   <= red;
									d_q[0]  <= 1'b0;
									state_q <= S_EXP;
								end
								OP_SQB: begin
									b_q     <= red;
									state_q <= S_EXP;
								end
								OP_SQX: begin
									acc_q <= red;
									if (red == n_m1) begin
										verdict_q <= mrw_pkg::V_PASS;
										state_q   <= S_FIN;
									end else begin
										state_q <= S_SQL;
									end
								end
								default: state_q <= S_IDLE;
							endcase
						end
					end
				end
				S_CHK: begin
					if (acc_q == {{(W-1){1'b0}}, 1'b1} || acc_q == n_m1) begin
						verdict_q <= mrw_pkg::V_PASS;
						state_q   <= S_FIN;
					end else begin
						state_q <= S_SQL;
					end
				end
				S_SQL: begin
					if (rem_q == '0) begin
						verdict_q <= mrw_pkg::V_COMPOSITE;
						state_q   <= S_FIN;
					end else begin
						rem_q   <= rem_q - CW'(1);
						mx_q    <= acc_q;
						my_q    <= acc_q;
						r_q     <= '0;
						cnt_q   <= CW'(W - 1);
						ph_q    <= 1'b0;
						op_q    <= OP_SQX;
						state_q <= S_MUL;
					end
				end
				S_FIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign verdict = verdict_q;

endmodule

>>> src/mrw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrw_checker
// Port-level checks on the command and result channels of the witness round.
// ----------------------------------------------------------------------------
module mrw_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic [1:0]                verdict
);

	// every transfer makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transfer did not raise busy");

	// busy only drops when a verdict comes out
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (verdict == mrw_pkg::V_REJECT || verdict == mrw_pkg::V_COMPOSITE
			|| verdict == mrw_pkg::V_PASS))
		else $error("verdict code out of range");

endmodule

bind miller_rabin_witness_round mrw_checker u_mrw_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.verdict (verdict)
);
